// ----- rtl/core/qos_pkg.sv -----
// ============================================================================
// qos_pkg
// Shared types, widths and constants for the queue occupancy statistics block.
// ============================================================================
`default_nettype none

package qos_pkg;

  // FIFO geometry
  localparam int unsigned QUEUE_DEPTH = 64;
  localparam int unsigned PTR_W       = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned CNT_W       = $clog2(QUEUE_DEPTH + 1);
  // multiplier operand holds fill count plus busy flag
  localparam int unsigned MUL_W       = CNT_W + 1;

  // field widths
  localparam int unsigned TIME_W = 32;
  localparam int unsigned ACC_W  = 48;
  localparam int unsigned ARR_W  = 16;
  localparam int unsigned QLEN_W = 7;
  localparam int unsigned ERR_W  = 2;

  localparam logic [ARR_W-1:0] ARRIVAL_LIMIT_RESET = 16'd100;
  localparam logic [ARR_W-1:0] ARR_MAX             = '1;
  localparam logic [ACC_W-1:0] ACC_MAX             = '1;

  // result payload: 266 bits of fields, padded to whole bytes
  localparam int unsigned RES_W     = 1 + QLEN_W + ARR_W + 1 + 1 + 5 * ACC_W;
  localparam int unsigned TDATA_O_W = ((RES_W + 7) / 8) * 8;
  localparam int unsigned PAD_W     = TDATA_O_W - RES_W;

  // event kind carried on tuser
  typedef enum logic [0:0] {
    EV_ARRIVAL = 1'b0,
    EV_DEPART  = 1'b1
  } event_e;

  // error codes
  typedef enum logic [ERR_W-1:0] {
    ERR_NONE     = 2'd0,
    ERR_DROP     = 2'd1,
    ERR_IDLE_DEP = 2'd2
  } err_e;

  // sequencer states
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DELTA,
    ST_AREA_Q,
    ST_AREA_B,
    ST_AREA_S,
    ST_EVENT,
    ST_SOJOURN,
    ST_WAIT,
    ST_OUT
  } state_e;

  // subtractor operand select: event time minus ...
  typedef enum logic [1:0] {
    SUB_LAST,
    SUB_SERVICE,
    SUB_HEAD
  } sub_sel_e;

  // accumulator select for the multiply and saturating add
  typedef enum logic [2:0] {
    ACC_QUEUE,
    ACC_BUSY,
    ACC_SYSTEM,
    ACC_SOJOURN,
    ACC_WAIT
  } acc_sel_e;

  // sequencer to datapath control
  typedef struct packed {
    logic     in_ready;
    logic     sub_en;
    sub_sel_e sub_sel;
    logic     mac_en;
    acc_sel_e acc_sel;
    logic     ev_apply;
    logic     sj_apply;
    logic     wt_apply;
    logic     out_load;
  } ctrl_t;

  // FIFO access control
  typedef struct packed {
    logic             wr_en;
    logic [PTR_W-1:0] wr_addr;
    logic [PTR_W-1:0] rd_addr;
  } fifo_ctrl_t;

  // result word, last field (busy_res) in the lowest bits
  typedef struct packed {
    logic [PAD_W-1:0]  pad;
    logic [ACC_W-1:0]  total_sojourn;
    logic [ACC_W-1:0]  total_wait;
    logic [ACC_W-1:0]  area_system;
    logic [ACC_W-1:0]  area_busy;
    logic [ACC_W-1:0]  area_queue;
    logic              arrival_wanted;
    logic              service_started;
    logic [ARR_W-1:0]  arrived_count;
    logic [QLEN_W-1:0] queue_length;
    logic              busy_res;
  } result_t;

  // circular pointer advance
  function automatic logic [PTR_W-1:0] next_ptr(input logic [PTR_W-1:0] p);
    logic [PTR_W-1:0] r;
    if (p == PTR_W'(QUEUE_DEPTH - 1)) begin
      r = '0;
    end else begin
      r = p + PTR_W'(1);
    end
    return r;
  endfunction

endpackage

`default_nettype wire

// ----- rtl/core/qos_fifo.sv -----
// ============================================================================
// qos_fifo
// Arrival time store: one write port, one registered read port.
// ============================================================================
`default_nettype none

module qos_fifo (
  input  wire logic                        clk_i,
  input  wire qos_pkg::fifo_ctrl_t         ctrl_i,
  input  wire logic [qos_pkg::TIME_W-1:0]  wr_data_i,
  output logic      [qos_pkg::TIME_W-1:0]  rd_data_o
);

  logic [qos_pkg::TIME_W-1:0] mem [qos_pkg::QUEUE_DEPTH];
  logic [qos_pkg::TIME_W-1:0] rd_data_q;

  // write at tail, read head every cycle
  always_ff @(posedge clk_i) begin
    if (ctrl_i.wr_en) begin
      mem[ctrl_i.wr_addr] <= wr_data_i;
    end
    rd_data_q <= mem[ctrl_i.rd_addr];
  end

  assign rd_data_o = rd_data_q;

endmodule

`default_nettype wire

// ----- rtl/core/qos_alu.sv -----
// ============================================================================
// qos_alu
// Shared arithmetic: clamped time difference and saturating multiply-add.
// ============================================================================
`default_nettype none

module qos_alu (
  input  wire logic [qos_pkg::TIME_W-1:0] sub_a_i,
  input  wire logic [qos_pkg::TIME_W-1:0] sub_b_i,
  output logic      [qos_pkg::TIME_W-1:0] diff_o,
  input  wire logic [qos_pkg::ACC_W-1:0]  acc_i,
  input  wire logic [qos_pkg::MUL_W-1:0]  mult_i,
  input  wire logic [qos_pkg::TIME_W-1:0] delta_i,
  output logic      [qos_pkg::ACC_W-1:0]  sum_o
);

  localparam int unsigned PROD_W = qos_pkg::MUL_W + qos_pkg::TIME_W;

  logic [PROD_W-1:0]          prod;
  logic [qos_pkg::ACC_W:0]    sum;

  // elapsed ticks, negative taken as zero
  assign diff_o = (sub_a_i >= sub_b_i) ? (sub_a_i - sub_b_i) : '0;

  // weight times elapsed, added with saturation at all ones
  assign prod  = PROD_W'(mult_i) * PROD_W'(delta_i);
  assign sum   = {1'b0, acc_i} + (qos_pkg::ACC_W + 1)'(prod);
  assign sum_o = (sum >= {1'b0, qos_pkg::ACC_MAX}) ? qos_pkg::ACC_MAX
                                                   : sum[qos_pkg::ACC_W-1:0];

endmodule

`default_nettype wire

// ----- rtl/core/qos_seq.sv -----
// ============================================================================
// qos_seq
// Event sequencer: steps the shared unit through the area and delay updates.
// ============================================================================
`default_nettype none

module qos_seq (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           in_valid_i,
  input  wire qos_pkg::event_e func_i,
  input  wire logic           busy_i,
  input  wire logic           fill_nz_i,
  input  wire logic           out_free_i,
  output qos_pkg::ctrl_t      ctrl_o
);

  qos_pkg::state_e state_q, state_d;

  // state register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= qos_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      qos_pkg::ST_IDLE:    if (in_valid_i) state_d = qos_pkg::ST_DELTA;
      qos_pkg::ST_DELTA:   state_d = qos_pkg::ST_AREA_Q;
      qos_pkg::ST_AREA_Q:  state_d = qos_pkg::ST_AREA_B;
      qos_pkg::ST_AREA_B:  state_d = qos_pkg::ST_AREA_S;
      qos_pkg::ST_AREA_S:  state_d = qos_pkg::ST_EVENT;
      qos_pkg::ST_EVENT: begin
        if (func_i == qos_pkg::EV_DEPART && busy_i) begin
          state_d = qos_pkg::ST_SOJOURN;
        end else begin
          state_d = qos_pkg::ST_OUT;
        end
      end
      qos_pkg::ST_SOJOURN: state_d = fill_nz_i ? qos_pkg::ST_WAIT : qos_pkg::ST_OUT;
      qos_pkg::ST_WAIT:    state_d = qos_pkg::ST_OUT;
      qos_pkg::ST_OUT:     if (out_free_i) state_d = qos_pkg::ST_IDLE;
      default:             state_d = qos_pkg::ST_IDLE;
    endcase
  end

  // control outputs
  always_comb begin
    ctrl_o         = '0;
    ctrl_o.sub_sel = qos_pkg::SUB_LAST;
    ctrl_o.acc_sel = qos_pkg::ACC_QUEUE;
    unique case (state_q)
      qos_pkg::ST_IDLE:   ctrl_o.in_ready = 1'b1;
      qos_pkg::ST_DELTA: begin
        ctrl_o.sub_en  = 1'b1;
        ctrl_o.sub_sel = qos_pkg::SUB_LAST;
      end
      qos_pkg::ST_AREA_Q: begin
        ctrl_o.mac_en  = 1'b1;
        ctrl_o.acc_sel = qos_pkg::ACC_QUEUE;
      end
      qos_pkg::ST_AREA_B: begin
        ctrl_o.mac_en  = 1'b1;
        ctrl_o.acc_sel = qos_pkg::ACC_BUSY;
      end
      qos_pkg::ST_AREA_S: begin
        ctrl_o.mac_en  = 1'b1;
        ctrl_o.acc_sel = qos_pkg::ACC_SYSTEM;
      end
      qos_pkg::ST_EVENT: begin
        // sojourn delay prepared alongside the event update
        ctrl_o.ev_apply = 1'b1;
        ctrl_o.sub_en   = 1'b1;
        ctrl_o.sub_sel  = qos_pkg::SUB_SERVICE;
      end
      qos_pkg::ST_SOJOURN: begin
        // add sojourn, prepare queuing delay of the head item
        ctrl_o.mac_en   = 1'b1;
        ctrl_o.acc_sel  = qos_pkg::ACC_SOJOURN;
        ctrl_o.sub_en   = 1'b1;
        ctrl_o.sub_sel  = qos_pkg::SUB_HEAD;
        ctrl_o.sj_apply = 1'b1;
      end
      qos_pkg::ST_WAIT: begin
        ctrl_o.mac_en   = 1'b1;
        ctrl_o.acc_sel  = qos_pkg::ACC_WAIT;
        ctrl_o.wt_apply = 1'b1;
      end
      qos_pkg::ST_OUT:    ctrl_o.out_load = out_free_i;
      default:            ctrl_o.in_ready = 1'b0;
    endcase
  end

endmodule

`default_nettype wire

// ----- rtl/core/queue_occupancy_statistics_top.sv -----
// ============================================================================
// queue_occupancy_statistics_top
// Single-server queue monitor with time-weighted areas and delay totals.
// ============================================================================
// Each input transaction is one event (arrival or departure) with a tick
// timestamp; each event yields exactly one result transaction. The block is
// not ready while an event is in work: an arrival or a departure while idle
// steps through the elapsed-time, three area and event states, a departure
// that empties the server adds the sojourn step and a departure that starts
// the next queued item adds the wait step too; the final output step waits
// while the previous result is still held on m_axis_tready_i. The work runs on
// the one shared multiply and saturating-add unit, which updates the five
// 48-bit accumulators one per cycle. The arrival time FIFO is a 64-entry
// memory with a registered read port; its contents are undefined after reset.
// ============================================================================
`default_nettype none

module queue_occupancy_statistics_top (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  // configuration: arrival_limit
  input  wire logic                          cfg_wr_en_i,
  input  wire logic [qos_pkg::ARR_W-1:0]     cfg_wr_data_i,
  // event stream in
  input  wire logic                          s_axis_tvalid_i,
  output logic                               s_axis_tready_o,
  input  wire logic [qos_pkg::TIME_W-1:0]    s_axis_tdata_i,  // [31:0] event_time
  input  wire logic                          s_axis_tuser_i,  // [0] func
  // result stream out
  output logic                               m_axis_tvalid_o,
  input  wire logic                          m_axis_tready_i,
  // tdata: [0] busy_res, [7:1] queue_length, [23:8] arrived_count,
  // [24] service_started, [25] arrival_wanted, [73:26] area_queue,
  // [121:74] area_busy, [169:122] area_system, [217:170] total_wait,
  // [265:218] total_sojourn, [271:266] zero
  output logic [qos_pkg::TDATA_O_W-1:0]      m_axis_tdata_o,
  output logic [qos_pkg::ERR_W-1:0]          m_axis_tuser_o   // [1:0] error
);

  qos_pkg::ctrl_t       ctrl;
  qos_pkg::fifo_ctrl_t  fifo_ctrl;

  // event capture
  qos_pkg::event_e              func_q;
  logic [qos_pkg::TIME_W-1:0]   now_q;

  // queue state
  logic [qos_pkg::PTR_W-1:0]    head_q, tail_q;
  logic [qos_pkg::CNT_W-1:0]    fill_q;
  logic                         busy_q;
  logic [qos_pkg::TIME_W-1:0]   svc_arr_q, last_time_q, delta_q;
  logic [qos_pkg::ARR_W-1:0]    arrivals_q, limit_q;
  logic [qos_pkg::ACC_W-1:0]    acc_queue_q, acc_busy_q, acc_system_q;
  logic [qos_pkg::ACC_W-1:0]    acc_wait_q, acc_sojourn_q;
  logic                         started_q;
  qos_pkg::err_e                err_q;

  // output register
  logic                         out_valid_q;
  qos_pkg::result_t             out_res_q;
  qos_pkg::err_e                out_err_q;

  // shared unit operands
  logic [qos_pkg::TIME_W-1:0]   sub_b, diff, fifo_rd;
  logic [qos_pkg::ACC_W-1:0]    acc_in, mac_sum;
  logic [qos_pkg::MUL_W-1:0]    mult;
  logic                         fifo_full, out_free;

  assign fifo_full = (fill_q == qos_pkg::CNT_W'(qos_pkg::QUEUE_DEPTH));
  assign out_free  = !out_valid_q || m_axis_tready_i;

  // sequencer
  qos_seq u_seq (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid_i),
    .func_i     (func_q),
    .busy_i     (busy_q),
    .fill_nz_i  (fill_q != '0),
    .out_free_i (out_free),
    .ctrl_o     (ctrl)
  );

  // arrival time store
  assign fifo_ctrl.wr_en   = ctrl.ev_apply && (func_q == qos_pkg::EV_ARRIVAL)
                             && busy_q && !fifo_full;
  assign fifo_ctrl.wr_addr = tail_q;
  assign fifo_ctrl.rd_addr = head_q;

  qos_fifo u_fifo (
    .clk_i     (clk_i),
    .ctrl_i    (fifo_ctrl),
    .wr_data_i (now_q),
    .rd_data_o (fifo_rd)
  );

  // operand selection for the shared unit
  always_comb begin
    unique case (ctrl.sub_sel)
      qos_pkg::SUB_LAST:    sub_b = last_time_q;
      qos_pkg::SUB_SERVICE: sub_b = svc_arr_q;
      qos_pkg::SUB_HEAD:    sub_b = fifo_rd;
      default:              sub_b = last_time_q;
    endcase
  end

  always_comb begin
    unique case (ctrl.acc_sel)
      qos_pkg::ACC_QUEUE: begin
        acc_in = acc_queue_q;
        mult   = qos_pkg::MUL_W'(fill_q);
      end
      qos_pkg::ACC_BUSY: begin
        acc_in = acc_busy_q;
        mult   = qos_pkg::MUL_W'(busy_q);
      end
      qos_pkg::ACC_SYSTEM: begin
        acc_in = acc_system_q;
        mult   = qos_pkg::MUL_W'(fill_q) + qos_pkg::MUL_W'(busy_q);
      end
      qos_pkg::ACC_SOJOURN: begin
        acc_in = acc_sojourn_q;
        mult   = qos_pkg::MUL_W'(1);
      end
      qos_pkg::ACC_WAIT: begin
        acc_in = acc_wait_q;
        mult   = qos_pkg::MUL_W'(1);
      end
      default: begin
        acc_in = acc_queue_q;
        mult   = '0;
      end
    endcase
  end

  qos_alu u_alu (
    .sub_a_i (now_q),
    .sub_b_i (sub_b),
    .diff_o  (diff),
    .acc_i   (acc_in),
    .mult_i  (mult),
    .delta_i (delta_q),
    .sum_o   (mac_sum)
  );

  // event capture and elapsed-time register (payload, no reset)
  always_ff @(posedge clk_i) begin
    if (ctrl.in_ready && s_axis_tvalid_i) begin
      func_q <= qos_pkg::event_e'(s_axis_tuser_i);
      now_q  <= s_axis_tdata_i;
    end
    if (ctrl.sub_en) begin
      delta_q <= diff;
    end
  end

  // queue bookkeeping and accumulators
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q        <= '0;
      tail_q        <= '0;
      fill_q        <= '0;
      busy_q        <= 1'b0;
      svc_arr_q     <= '0;
      last_time_q   <= '0;
      arrivals_q    <= '0;
      limit_q       <= qos_pkg::ARRIVAL_LIMIT_RESET;
      acc_queue_q   <= '0;
      acc_busy_q    <= '0;
      acc_system_q  <= '0;
      acc_wait_q    <= '0;
      acc_sojourn_q <= '0;
      started_q     <= 1'b0;
      err_q         <= qos_pkg::ERR_NONE;
    end else begin
      if (cfg_wr_en_i) begin
        limit_q <= cfg_wr_data_i;
      end
      if (ctrl.in_ready && s_axis_tvalid_i) begin
        started_q <= 1'b0;
        err_q     <= qos_pkg::ERR_NONE;
      end
      if (ctrl.sub_en && ctrl.sub_sel == qos_pkg::SUB_LAST) begin
        last_time_q <= now_q;
      end
      // write back the selected accumulator
      if (ctrl.mac_en) begin
        unique case (ctrl.acc_sel)
          qos_pkg::ACC_QUEUE:   acc_queue_q   <= mac_sum;
          qos_pkg::ACC_BUSY:    acc_busy_q    <= mac_sum;
          qos_pkg::ACC_SYSTEM:  acc_system_q  <= mac_sum;
          qos_pkg::ACC_SOJOURN: acc_sojourn_q <= mac_sum;
          qos_pkg::ACC_WAIT:    acc_wait_q    <= mac_sum;
          default:              acc_queue_q   <= acc_queue_q;
        endcase
      end
      // arrival, or departure while idle
      if (ctrl.ev_apply) begin
        if (func_q == qos_pkg::EV_ARRIVAL) begin
          if (arrivals_q != qos_pkg::ARR_MAX) begin
            arrivals_q <= arrivals_q + qos_pkg::ARR_W'(1);
          end
          priority if (!busy_q) begin
            busy_q    <= 1'b1;
            svc_arr_q <= now_q;
            started_q <= 1'b1;
          end else if (!fifo_full) begin
            tail_q <= qos_pkg::next_ptr(tail_q);
            fill_q <= fill_q + qos_pkg::CNT_W'(1);
          end else begin
            err_q <= qos_pkg::ERR_DROP;
          end
        end else if (!busy_q) begin
          err_q <= qos_pkg::ERR_IDLE_DEP;
        end
      end
      // departure with nothing waiting frees the server
      if (ctrl.sj_apply && fill_q == '0) begin
        busy_q <= 1'b0;
      end
      // head item enters service
      if (ctrl.wt_apply) begin
        head_q    <= qos_pkg::next_ptr(head_q);
        fill_q    <= fill_q - qos_pkg::CNT_W'(1);
        svc_arr_q <= fifo_rd;
        started_q <= 1'b1;
      end
    end
  end

  // output valid flag
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (ctrl.out_load) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  // result payload
  always_ff @(posedge clk_i) begin
    if (ctrl.out_load) begin
      out_res_q.pad             <= '0;
      out_res_q.total_sojourn   <= acc_sojourn_q;
      out_res_q.total_wait      <= acc_wait_q;
      out_res_q.area_system     <= acc_system_q;
      out_res_q.area_busy       <= acc_busy_q;
      out_res_q.area_queue      <= acc_queue_q;
      out_res_q.arrival_wanted  <= (arrivals_q < limit_q);
      out_res_q.service_started <= started_q;
      out_res_q.arrived_count   <= arrivals_q;
      out_res_q.queue_length    <= qos_pkg::QLEN_W'(fill_q);
      out_res_q.busy_res        <= busy_q;
      out_err_q                 <= err_q;
    end
  end

  assign s_axis_tready_o = ctrl.in_ready;
  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = out_res_q;
  assign m_axis_tuser_o  = out_err_q;

`ifndef SYNTH
  // fill count never passes the FIFO depth
  a_fill_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q <= qos_pkg::CNT_W'(qos_pkg::QUEUE_DEPTH))
    else $error("fill count above FIFO depth");

  // items wait only while the server is busy
  a_idle_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !busy_q |-> (fill_q == '0))
    else $error("items queued while server idle");

  // an accepted event blocks input until its result is formed
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid_i && s_axis_tready_o) |=> !s_axis_tready_o)
    else $error("input ready right after acceptance");

  // an errored event never starts service
  a_err_no_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && out_err_q != qos_pkg::ERR_NONE) |-> !out_res_q.service_started)
    else $error("service start flagged with error");
`endif

endmodule

`default_nettype wire

// ----- test/tb_queue_occupancy_statistics_top.sv -----
// ============================================================================
// tb_queue_occupancy_statistics_top
// Self-checking bench for the single-server queue statistics monitor.
// ============================================================================
// A mirror of the queue (arrival-time FIFO, busy flag, five saturating
// accumulators) predicts every result transaction from the accepted events.
// A short table of hand-picked events runs first, some rows carrying typed
// expectations. Random event mixes under several arrival limits follow,
// with random source gaps and sink stalls. A last run of back-to-back
// arrive/depart pairs at the extremes of the time range gives the widest
// spans and delays one after another.
// ============================================================================

module tb_queue_occupancy_statistics_top;

  localparam int STALL_LIMIT   = 400;
  localparam int SETTLE_CYCLES = 12;
  localparam int MAX_REPORTS   = 40;
  localparam int N_DIRECTED    = 20;
  localparam int PHASE_EVENTS  = 240;
  localparam int EXTREME_PAIRS = 16;

  // one expected result transaction
  typedef struct packed {
    qos_pkg::result_t res;
    qos_pkg::err_e    err;
  } outcome_t;

  // one directed event; typed fields apply only when checked is set
  typedef struct packed {
    qos_pkg::event_e            kind;
    logic [qos_pkg::TIME_W-1:0] stamp;
    logic                       checked;
    logic                       busy;
    logic [qos_pkg::QLEN_W-1:0] qlen;
    logic [qos_pkg::ARR_W-1:0]  arrived;
    logic                       started;
    qos_pkg::err_e              err;
  } stim_row_t;

  localparam stim_row_t DIRECTED_ROWS [N_DIRECTED] = '{
    // departure straight after reset: idle error
    '{qos_pkg::EV_DEPART,  32'h0000_0000, 1'b1, 1'b0, 7'd0, 16'd0, 1'b0, qos_pkg::ERR_IDLE_DEP},
    '{qos_pkg::EV_ARRIVAL, 32'h0000_0000, 1'b1, 1'b1, 7'd0, 16'd1, 1'b1, qos_pkg::ERR_NONE},
    '{qos_pkg::EV_ARRIVAL, 32'h0000_000A, 1'b1, 1'b1, 7'd1, 16'd2, 1'b0, qos_pkg::ERR_NONE},
    '{qos_pkg::EV_ARRIVAL, 32'h0000_000A, 1'b1, 1'b1, 7'd2, 16'd3, 1'b0, qos_pkg::ERR_NONE},
    // widest time step with a queue in place
    '{qos_pkg::EV_DEPART,  32'hFFFF_FFFF, 1'b1, 1'b1, 7'd1, 16'd3, 1'b1, qos_pkg::ERR_NONE},
    // time running backwards
    '{qos_pkg::EV_ARRIVAL, 32'h0000_0005, 1'b1, 1'b1, 7'd2, 16'd4, 1'b0, qos_pkg::ERR_NONE},
    '{qos_pkg::EV_DEPART,  32'h0000_0005, 1'b1, 1'b1, 7'd1, 16'd4, 1'b1, qos_pkg::ERR_NONE},
    '{qos_pkg::EV_DEPART,  32'h0000_0006, 1'b1, 1'b1, 7'd0, 16'd4, 1'b1, qos_pkg::ERR_NONE},
    '{qos_pkg::EV_DEPART,  32'h0000_0007, 1'b1, 1'b0, 7'd0, 16'd4, 1'b0, qos_pkg::ERR_NONE},
    '{qos_pkg::EV_DEPART,  32'h0000_0007, 1'b1, 1'b0, 7'd0, 16'd4, 1'b0, qos_pkg::ERR_IDLE_DEP},
    '{qos_pkg::EV_ARRIVAL, 32'hFFFF_FFFF, 1'b1, 1'b1, 7'd0, 16'd5, 1'b1, qos_pkg::ERR_NONE},
    '{qos_pkg::EV_ARRIVAL, 32'h0000_0000, 1'b1, 1'b1, 7'd1, 16'd6, 1'b0, qos_pkg::ERR_NONE},
    // largest single queuing delay
    '{qos_pkg::EV_DEPART,  32'hFFFF_FFFF, 1'b1, 1'b1, 7'd0, 16'd6, 1'b1, qos_pkg::ERR_NONE},
    '{qos_pkg::EV_DEPART,  32'hFFFF_FFFF, 1'b1, 1'b0, 7'd0, 16'd6, 1'b0, qos_pkg::ERR_NONE},
    '{qos_pkg::EV_ARRIVAL, 32'h8000_0000, 1'b0, 1'b0, 7'd0, 16'd0, 1'b0, qos_pkg::ERR_NONE},
    '{qos_pkg::EV_ARRIVAL, 32'h8000_0000, 1'b0, 1'b0, 7'd0, 16'd0, 1'b0, qos_pkg::ERR_NONE},
    '{qos_pkg::EV_ARRIVAL, 32'h5555_5555, 1'b0, 1'b0, 7'd0, 16'd0, 1'b0, qos_pkg::ERR_NONE},
    '{qos_pkg::EV_DEPART,  32'hAAAA_AAAA, 1'b0, 1'b0, 7'd0, 16'd0, 1'b0, qos_pkg::ERR_NONE},
    '{qos_pkg::EV_DEPART,  32'h7FFF_FFFF, 1'b0, 1'b0, 7'd0, 16'd0, 1'b0, qos_pkg::ERR_NONE},
    '{qos_pkg::EV_DEPART,  32'hFFFF_FFFF, 1'b0, 1'b0, 7'd0, 16'd0, 1'b0, qos_pkg::ERR_NONE}
  };

  // DUT ports
  logic                            clk_i           = 1'b0;
  logic                            rst_ni          = 1'b0;
  logic                            cfg_wr_en_i     = 1'b0;
  logic [qos_pkg::ARR_W-1:0]       cfg_wr_data_i   = '0;
  logic                            s_axis_tvalid_i = 1'b0;
  logic                            s_axis_tready_o;
  logic [qos_pkg::TIME_W-1:0]      s_axis_tdata_i  = '0;
  logic                            s_axis_tuser_i  = 1'b0;
  logic                            m_axis_tvalid_o;
  logic                            m_axis_tready_i = 1'b0;
  logic [qos_pkg::TDATA_O_W-1:0]   m_axis_tdata_o;
  logic [qos_pkg::ERR_W-1:0]       m_axis_tuser_o;

  // mirror of the queue state
  logic [qos_pkg::TIME_W-1:0] arr_times [qos_pkg::QUEUE_DEPTH];
  int unsigned                rd_slot     = 0;
  int unsigned                wr_slot     = 0;
  logic [qos_pkg::QLEN_W-1:0] waiting     = '0;
  logic                       serving     = 1'b0;
  logic [qos_pkg::TIME_W-1:0] svc_since   = '0;
  logic [qos_pkg::TIME_W-1:0] prev_stamp  = '0;
  logic [qos_pkg::ARR_W-1:0]  n_arrivals  = '0;
  logic [qos_pkg::ARR_W-1:0]  arr_limit   = qos_pkg::ARRIVAL_LIMIT_RESET;
  logic [qos_pkg::ACC_W-1:0]  area_q      = '0;
  logic [qos_pkg::ACC_W-1:0]  area_b      = '0;
  logic [qos_pkg::ACC_W-1:0]  area_s      = '0;
  logic [qos_pkg::ACC_W-1:0]  sum_wait    = '0;
  logic [qos_pkg::ACC_W-1:0]  sum_sojourn = '0;

  outcome_t                   pending_results [$];
  int                         mismatches   = 0;
  int                         src_max_gap  = 4;
  int                         sink_max_gap = 4;
  int                         sink_hold    = 0;
  int                         quiet_cycles = 0;
  logic [qos_pkg::TIME_W-1:0] stim_time    = '0;

  queue_occupancy_statistics_top u_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_wr_en_i     (cfg_wr_en_i),
    .cfg_wr_data_i   (cfg_wr_data_i),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .s_axis_tuser_i  (s_axis_tuser_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tuser_o  (m_axis_tuser_o)
  );

  always #2 clk_i = ~clk_i;

  // negative spans count as zero
  function automatic logic [qos_pkg::TIME_W-1:0] ticks_since(
      input logic [qos_pkg::TIME_W-1:0] now,
      input logic [qos_pkg::TIME_W-1:0] then_t);
    return (now >= then_t) ? now - then_t : '0;
  endfunction

  function automatic logic [qos_pkg::ACC_W-1:0] sat_acc(
      input logic [qos_pkg::ACC_W-1:0] acc,
      input logic [63:0]               inc);
    logic [63:0] room;
    room = 64'(qos_pkg::ACC_MAX) - 64'(acc);
    if (acc == qos_pkg::ACC_MAX || inc >= room) begin
      return qos_pkg::ACC_MAX;
    end
    return acc + inc[qos_pkg::ACC_W-1:0];
  endfunction

  // advance the mirror by one event and return the result it should produce
  function automatic outcome_t tally_event(input qos_pkg::event_e            kind,
                                           input logic [qos_pkg::TIME_W-1:0] now);
    outcome_t                   o;
    logic [63:0]                dt;
    logic [qos_pkg::TIME_W-1:0] head;
    o     = '0;
    o.err = qos_pkg::ERR_NONE;
    dt    = 64'(ticks_since(now, prev_stamp));

    // areas over the span since the previous event
    area_q     = sat_acc(area_q, 64'(waiting) * dt);
    area_b     = sat_acc(area_b, serving ? dt : 64'd0);
    area_s     = sat_acc(area_s, (64'(waiting) + 64'(serving)) * dt);
    prev_stamp = now;

    if (kind == qos_pkg::EV_ARRIVAL) begin
      if (n_arrivals != qos_pkg::ARR_MAX) begin
        n_arrivals = n_arrivals + 1'b1;
      end
      if (!serving) begin
        serving               = 1'b1;
        svc_since             = now;
        o.res.service_started = 1'b1;
      end else if (waiting < qos_pkg::QUEUE_DEPTH) begin
        arr_times[wr_slot] = now;
        wr_slot            = (wr_slot + 1) % qos_pkg::QUEUE_DEPTH;
        waiting            = waiting + 1'b1;
      end else begin
        o.err = qos_pkg::ERR_DROP;
      end
    end else if (!serving) begin
      o.err = qos_pkg::ERR_IDLE_DEP;
    end else begin
      sum_sojourn = sat_acc(sum_sojourn, 64'(ticks_since(now, svc_since)));
      if (waiting != 0) begin
        head                  = arr_times[rd_slot];
        rd_slot               = (rd_slot + 1) % qos_pkg::QUEUE_DEPTH;
        waiting               = waiting - 1'b1;
        sum_wait              = sat_acc(sum_wait, 64'(ticks_since(now, head)));
        svc_since             = head;
        o.res.service_started = 1'b1;
      end else begin
        serving = 1'b0;
      end
    end

    o.res.busy_res       = serving;
    o.res.queue_length   = waiting;
    o.res.arrived_count  = n_arrivals;
    o.res.arrival_wanted = (n_arrivals < arr_limit);
    o.res.area_queue     = area_q;
    o.res.area_busy      = area_b;
    o.res.area_system    = area_s;
    o.res.total_wait     = sum_wait;
    o.res.total_sojourn  = sum_sojourn;
    return o;
  endfunction

  function automatic void check_field(input string name, input logic [63:0] want,
                                      input logic [63:0] got);
    if (want !== got) begin
      if (mismatches < MAX_REPORTS) begin
        $display("%0t: %s expected %h got %h", $time, name, want, got);
      end
      mismatches++;
    end
  endfunction

  // present one event and hold it until the transaction completes
  task automatic drive_event(input qos_pkg::event_e            kind,
                             input logic [qos_pkg::TIME_W-1:0] stamp);
    int gap;
    gap = $urandom_range(0, src_max_gap);
    if (gap > 0) begin
      s_axis_tvalid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tuser_i  <= kind;
    s_axis_tdata_i  <= stamp;
    @(posedge clk_i);
    while (!s_axis_tready_o) @(posedge clk_i);
  endtask

  task automatic post_event(input qos_pkg::event_e            kind,
                            input logic [qos_pkg::TIME_W-1:0] stamp);
    drive_event(kind, stamp);
    pending_results.push_back(tally_event(kind, stamp));
  endtask

  // register write, only once the block has drained
  task automatic write_arrival_limit(input logic [qos_pkg::ARR_W-1:0] value);
    s_axis_tvalid_i <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    cfg_wr_en_i   <= 1'b1;
    cfg_wr_data_i <= value;
    @(posedge clk_i);
    cfg_wr_en_i   <= 1'b0;
    arr_limit = value;
  endtask

  // random event mix; timestamps mostly creep forward, sometimes jump or step back
  task automatic run_random_events(input int count, input int arrival_pct);
    qos_pkg::event_e kind;
    int              pick;
    for (int i = 0; i < count; i++) begin
      kind = ($urandom_range(0, 99) < arrival_pct) ? qos_pkg::EV_ARRIVAL
                                                   : qos_pkg::EV_DEPART;
      pick = $urandom_range(0, 99);
      if (pick < 3) begin
        stim_time = $urandom;
      end else if (pick < 6) begin
        // same tick again
      end else if (pick < 10) begin
        stim_time = stim_time - $urandom_range(1, 64);
      end else if (pick < 15) begin
        stim_time = stim_time + $urandom_range(0, 32'h00FF_FFFF);
      end else begin
        stim_time = stim_time + $urandom_range(1, 40);
      end
      post_event(kind, stim_time);
    end
  endtask

  // result side: random stalls, compare against the oldest expectation
  always @(posedge clk_i) begin
    qos_pkg::result_t got;
    outcome_t         want;
    if (rst_ni) begin
      if (m_axis_tvalid_o && m_axis_tready_i) begin
        got = qos_pkg::result_t'(m_axis_tdata_o);
        if (pending_results.size() == 0) begin
          if (mismatches < MAX_REPORTS) begin
            $display("%0t: unexpected result transaction %h", $time, m_axis_tdata_o);
          end
          mismatches++;
        end else begin
          want = pending_results.pop_front();
          check_field("busy_res", want.res.busy_res, got.busy_res);
          check_field("queue_length", want.res.queue_length, got.queue_length);
          check_field("arrived_count", want.res.arrived_count, got.arrived_count);
          check_field("service_started", want.res.service_started, got.service_started);
          check_field("arrival_wanted", want.res.arrival_wanted, got.arrival_wanted);
          check_field("area_queue", want.res.area_queue, got.area_queue);
          check_field("area_busy", want.res.area_busy, got.area_busy);
          check_field("area_system", want.res.area_system, got.area_system);
          check_field("total_wait", want.res.total_wait, got.total_wait);
          check_field("total_sojourn", want.res.total_sojourn, got.total_sojourn);
          check_field("padding", '0, got.pad);
          check_field("error", want.err, m_axis_tuser_o);
        end
        sink_hold = $urandom_range(0, sink_max_gap);
      end else if (!m_axis_tready_i && sink_hold > 0) begin
        sink_hold--;
      end
      m_axis_tready_i <= (sink_hold == 0);
    end
  end

  // watchdog on cycles without any transaction
  always @(posedge clk_i) begin
    if ((s_axis_tvalid_i && s_axis_tready_o) || (m_axis_tvalid_o && m_axis_tready_i)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("%0t: no transaction for %0d cycles", $time, STALL_LIMIT);
      $display("queue_occupancy_statistics_top regression: fail");
      $finish;
    end
  end

  initial begin
    outcome_t  want;
    stim_row_t row;

    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed events under the reset arrival limit
    for (int i = 0; i < N_DIRECTED; i++) begin
      row = DIRECTED_ROWS[i];
      drive_event(row.kind, row.stamp);
      want = tally_event(row.kind, row.stamp);
      if (row.checked) begin
        want.res.busy_res        = row.busy;
        want.res.queue_length    = row.qlen;
        want.res.arrived_count   = row.arrived;
        want.res.service_started = row.started;
        want.err                 = row.err;
      end
      pending_results.push_back(want);
    end
    stim_time = '0;

    // arrival-heavy: fills the FIFO and forces drops
    write_arrival_limit(16'hFFFF);
    run_random_events(PHASE_EVENTS, 85);

    write_arrival_limit(16'h0000);
    run_random_events(PHASE_EVENTS, 50);

    // limit just ahead of the count so arrival_wanted falls mid-run
    write_arrival_limit(n_arrivals + 16'd20);
    run_random_events(PHASE_EVENTS, 30);

    // back-to-back stretch with no idling on either side
    src_max_gap  = 0;
    sink_max_gap = 0;
    write_arrival_limit(16'($urandom_range(0, 16'hFFFF)));
    run_random_events(PHASE_EVENTS, 60);

    src_max_gap  = 4;
    sink_max_gap = 4;
    write_arrival_limit(16'd1);
    run_random_events(PHASE_EVENTS, 55);

    // extremes: arrive at tick 0, depart at the last tick, back to back
    src_max_gap  = 0;
    sink_max_gap = 0;
    write_arrival_limit(16'hFFFF);
    post_event(qos_pkg::EV_ARRIVAL, 32'h0000_0000);
    for (int i = 0; i < EXTREME_PAIRS; i++) begin
      post_event(qos_pkg::EV_ARRIVAL, 32'h0000_0000);
      post_event(qos_pkg::EV_DEPART, 32'hFFFF_FFFF);
    end

    // drain and finish
    s_axis_tvalid_i <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("queue_occupancy_statistics_top regression: pass");
    end else begin
      $display("queue_occupancy_statistics_top regression: fail");
    end
    $finish;
  end

endmodule

// ----- files.f -----
rtl/core/qos_pkg.sv
rtl/core/qos_fifo.sv
rtl/core/qos_alu.sv
rtl/core/qos_seq.sv
rtl/core/queue_occupancy_statistics_top.sv
test/tb_queue_occupancy_statistics_top.sv
